// ===== sv/rfcma_pkg.sv =====
// Package for the range filter, calibration and moving average unit.
// Holds the port payload types, the configuration types and fixed widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rfcma_pkg;

  localparam int RAW_W   = 16;
  localparam int CAL_W   = 24;
  localparam int CFG_W   = 24;
  localparam int COUNT_W = 9;

  localparam logic signed [CAL_W-1:0] CAL_MAX = 24'sh7fffff;
  localparam logic signed [CAL_W-1:0] CAL_MIN = 24'sh800000;
  localparam logic [COUNT_W-1:0]      COUNT_MAX = 9'd511;

  typedef enum logic [1:0] {
    CFG_LOWER_LIMIT = 2'd0,
    CFG_UPPER_LIMIT = 2'd1,
    CFG_GAIN        = 2'd2,
    CFG_OFFSET      = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [RAW_W-1:0] raw_sample;
    logic                    end_of_batch;
  } in_t;

  typedef struct packed {
    logic signed [CAL_W-1:0] average;
    logic                    has_average;
    logic                    batch_done;
    logic [COUNT_W-1:0]      average_count;
  } out_t;

  typedef struct packed {
    logic signed [RAW_W-1:0] lower_limit;
    logic signed [RAW_W-1:0] upper_limit;
    logic signed [RAW_W-1:0] gain;
    logic signed [CAL_W-1:0] offset;
  } cfg_t;

  typedef struct packed {
    logic signed [CAL_W-1:0] value;
    logic                    keep;
    logic                    last;
  } cal_t;

  typedef struct packed {
    logic               has_mean;
    logic               last;
    logic [COUNT_W-1:0] count;
  } ctl_t;

endpackage

`default_nettype wire

// ===== sv/rfcma_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Read returns the contents before a write to the same address in that cycle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rfcma_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                             wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== sv/rfcma_calib.sv =====
// Range check and gain/offset calibration, two register stages.
// Depends on rfcma_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rfcma_calib (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rfcma_pkg::cfg_t  cfg_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire rfcma_pkg::in_t   in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output rfcma_pkg::cal_t       out_data_o
);

  localparam int PROD_W = 2 * rfcma_pkg::RAW_W;

  logic                                 va_q;
  logic signed [PROD_W-1:0]             prod_q;
  logic                                 keep_a_q;
  logic                                 last_a_q;
  logic                                 ready_b;
  logic                                 vb_q;
  rfcma_pkg::cal_t                      cal_q;

  logic signed [rfcma_pkg::RAW_W-1:0]   raw;
  logic signed [rfcma_pkg::RAW_W-1:0]   lower;
  logic signed [rfcma_pkg::RAW_W-1:0]   upper;
  logic signed [rfcma_pkg::RAW_W-1:0]   gain;
  logic signed [rfcma_pkg::CAL_W-1:0]   offset;
  logic signed [PROD_W-1:0]             prod;
  logic signed [rfcma_pkg::CAL_W-1:0]   scaled;
  logic signed [rfcma_pkg::CAL_W:0]     sum;
  logic signed [rfcma_pkg::CAL_W-1:0]   sat;

  assign raw    = in_data_i.raw_sample;
  assign lower  = cfg_i.lower_limit;
  assign upper  = cfg_i.upper_limit;
  assign gain   = cfg_i.gain;
  assign offset = cfg_i.offset;
  assign prod   = raw * gain;

  assign ready_b    = !vb_q || out_ready_i;
  assign in_ready_o = !va_q || ready_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (in_ready_o) begin
      va_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      prod_q   <= prod;
      keep_a_q <= (raw >= lower) && (raw <= upper);
      last_a_q <= in_data_i.end_of_batch;
    end
  end

  // The arithmetic right shift divides by 256 rounding toward minus infinity.
  assign scaled = prod_q[PROD_W-1:8];
  assign sum    = (rfcma_pkg::CAL_W + 1)'(scaled) + (rfcma_pkg::CAL_W + 1)'(offset);

  always_comb begin
    if (sum > (rfcma_pkg::CAL_W + 1)'(rfcma_pkg::CAL_MAX)) begin
      sat = rfcma_pkg::CAL_MAX;
    end else if (sum < (rfcma_pkg::CAL_W + 1)'(rfcma_pkg::CAL_MIN)) begin
      sat = rfcma_pkg::CAL_MIN;
    end else begin
      sat = sum[rfcma_pkg::CAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (ready_b) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_b && va_q) begin
      cal_q.value <= sat;
      cal_q.keep  <= keep_a_q;
      cal_q.last  <= last_a_q;
    end
  end

  assign out_valid_o = vb_q;
  assign out_data_o  = cal_q;

endmodule

`default_nettype wire

// ===== sv/rfcma_window.sv =====
// Window delay line, running sum and batch counters, one register stage.
// Depends on rfcma_pkg and rfcma_ram.
`timescale 1ns / 1ps
`default_nettype none

module rfcma_window #(
  parameter int WINDOW       = 8,
  parameter int MAX_ACCEPTED = 256,
  parameter int OUT_CAPACITY = 256,
  parameter int SUM_W        = 27
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire rfcma_pkg::cal_t         in_data_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic signed [SUM_W-1:0]      out_sum_o,
  output rfcma_pkg::ctl_t              out_ctl_o
);

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int KW     = $clog2(MAX_ACCEPTED + 1);
  localparam int MW     = $clog2(OUT_CAPACITY + 1);
  localparam int CW     = (MW > rfcma_pkg::COUNT_W) ? MW : rfcma_pkg::COUNT_W;

  logic [SLOT_W-1:0]                   slot_q, slot_d;
  logic                                full_q;
  logic [KW-1:0]                       kept_q;
  logic [MW-1:0]                       means_q;
  logic signed [SUM_W-1:0]             sum_q;
  logic                                byp_q;
  logic [rfcma_pkg::CAL_W-1:0]         byp_data_q;
  logic                                v_q;
  logic signed [SUM_W-1:0]             out_sum_q;
  rfcma_pkg::ctl_t                     out_ctl_q;

  logic                                take;
  logic                                accept;
  logic                                wrap;
  logic                                have_mean;
  logic [rfcma_pkg::CAL_W-1:0]         rd_data;
  logic signed [rfcma_pkg::CAL_W-1:0]  old;
  logic signed [SUM_W-1:0]             sum_next;
  logic [MW-1:0]                       means_next;
  logic [CW-1:0]                       means_ext;
  logic [rfcma_pkg::COUNT_W-1:0]       count;

  assign in_ready_o = !v_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;
  assign accept     = take && in_data_i.keep && (kept_q < KW'(MAX_ACCEPTED));
  assign wrap       = (slot_q == SLOT_W'(WINDOW - 1));
  assign have_mean  = accept && (full_q || wrap) && (means_q < MW'(OUT_CAPACITY));

  always_comb begin
    slot_d = slot_q;
    if (take && in_data_i.last) begin
      slot_d = '0;
    end else if (accept) begin
      slot_d = wrap ? '0 : slot_q + SLOT_W'(1);
    end
  end

  rfcma_ram #(
    .WIDTH(rfcma_pkg::CAL_W),
    .DEPTH(WINDOW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (slot_q),
    .wdata_i (in_data_i.value),
    .raddr_i (slot_d),
    .rdata_o (rd_data)
  );

  assign old        = full_q ? (byp_q ? byp_data_q : rd_data) : '0;
  assign sum_next   = sum_q - SUM_W'(old) + SUM_W'(in_data_i.value);
  assign means_next = means_q + MW'(have_mean);
  assign means_ext  = CW'(means_next);
  assign count      = (means_ext > CW'(rfcma_pkg::COUNT_MAX)) ? rfcma_pkg::COUNT_MAX
                                                              : means_ext[rfcma_pkg::COUNT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      full_q  <= 1'b0;
      kept_q  <= '0;
      means_q <= '0;
      sum_q   <= '0;
      byp_q   <= 1'b0;
      v_q     <= 1'b0;
    end else begin
      slot_q <= slot_d;
      byp_q  <= accept && (slot_q == slot_d);
      if (take && in_data_i.last) begin
        full_q  <= 1'b0;
        kept_q  <= '0;
        means_q <= '0;
        sum_q   <= '0;
      end else if (accept) begin
        full_q  <= full_q || wrap;
        kept_q  <= kept_q + KW'(1);
        means_q <= means_next;
        sum_q   <= sum_next;
      end
      if (in_ready_o) begin
        v_q <= take && (have_mean || in_data_i.last);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= in_data_i.value;
    if (take) begin
      out_sum_q          <= sum_next;
      out_ctl_q.has_mean <= have_mean;
      out_ctl_q.last     <= in_data_i.last;
      out_ctl_q.count    <= count;
    end
  end

  assign out_valid_o = v_q;
  assign out_sum_o   = out_sum_q;
  assign out_ctl_o   = out_ctl_q;

endmodule

`default_nettype wire

// ===== sv/rfcma_divide.sv =====
// Window mean: signed sum divided by the window length, rounded toward zero,
// by an exact reciprocal multiplication over two register stages.
// Depends on rfcma_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rfcma_divide #(
  parameter int WINDOW = 8,
  parameter int SUM_W  = 27
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic signed [SUM_W-1:0] in_sum_i,
  input  wire rfcma_pkg::ctl_t         in_ctl_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output rfcma_pkg::out_t              out_data_o
);

  localparam int          L       = $clog2(WINDOW);
  localparam int          SH      = SUM_W + L;
  localparam int          RECIP_W = SUM_W + 2;
  localparam int          PROD_W  = SUM_W + RECIP_W;
  localparam logic [63:0] RECIP   = ((64'd1 << SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);

  logic                               va_q;
  logic [PROD_W-1:0]                  prod_q;
  logic                               neg_q;
  rfcma_pkg::ctl_t                    ctl_q;
  logic                               ready_b;
  logic                               vb_q;
  rfcma_pkg::out_t                    out_q;

  logic                               neg;
  logic [SUM_W-1:0]                   mag;
  logic [PROD_W-1:0]                  prod;
  logic [rfcma_pkg::CAL_W-1:0]        quo;
  logic [rfcma_pkg::CAL_W-1:0]        mean;

  assign neg  = in_sum_i[SUM_W-1];
  assign mag  = neg ? (~in_sum_i + SUM_W'(1)) : in_sum_i;
  assign prod = mag * RECIP[RECIP_W-1:0];

  assign ready_b    = !vb_q || out_ready_i;
  assign in_ready_o = !va_q || ready_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        va_q <= in_valid_i;
      end
      if (ready_b) begin
        vb_q <= va_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      prod_q <= prod;
      neg_q  <= neg;
      ctl_q  <= in_ctl_i;
    end
  end

  assign quo  = prod_q[SH +: rfcma_pkg::CAL_W];
  assign mean = neg_q ? (~quo + rfcma_pkg::CAL_W'(1)) : quo;

  always_ff @(posedge clk_i) begin
    if (ready_b && va_q) begin
      out_q.average       <= ctl_q.has_mean ? mean : '0;
      out_q.has_average   <= ctl_q.has_mean;
      out_q.batch_done    <= ctl_q.last;
      out_q.average_count <= ctl_q.count;
    end
  end

  assign out_valid_o = vb_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== sv/range_filter_calibrate_moving_average_unit.sv =====
// Range filter, calibration and moving average, top level.
// One transaction is accepted every cycle unless out_stall_i backs up the
// five-stage register pipeline, which then raises in_stall_o.
// Reset restores the register defaults and clears the window sum and counters;
// window contents stay undefined until written. Depends on rfcma_pkg and all rfcma_ modules.
`timescale 1ns / 1ps
`default_nettype none

module range_filter_calibrate_moving_average_unit #(
  parameter int WINDOW       = 8,
  parameter int MAX_ACCEPTED = 256,
  parameter int OUT_CAPACITY = 256
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_index_i,
  input  wire logic [rfcma_pkg::CFG_W-1:0]   cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire rfcma_pkg::in_t                in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output rfcma_pkg::out_t                    out_data_o
);

  localparam int SUM_W = rfcma_pkg::CAL_W + $clog2(WINDOW);

  rfcma_pkg::cfg_t          cfg_q;
  logic                     calib_ready;
  logic                     cal_valid;
  rfcma_pkg::cal_t          cal_data;
  logic                     win_ready;
  logic                     win_valid;
  logic signed [SUM_W-1:0]  win_sum;
  rfcma_pkg::ctl_t          win_ctl;
  logic                     div_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lower_limit <= 16'sh8000;
      cfg_q.upper_limit <= 16'sh7fff;
      cfg_q.gain        <= 16'sh0100;
      cfg_q.offset      <= '0;
    end else if (cfg_we_i) begin
      case (rfcma_pkg::cfg_idx_e'(cfg_index_i))
        rfcma_pkg::CFG_LOWER_LIMIT: cfg_q.lower_limit <= cfg_data_i[rfcma_pkg::RAW_W-1:0];
        rfcma_pkg::CFG_UPPER_LIMIT: cfg_q.upper_limit <= cfg_data_i[rfcma_pkg::RAW_W-1:0];
        rfcma_pkg::CFG_GAIN:        cfg_q.gain        <= cfg_data_i[rfcma_pkg::RAW_W-1:0];
        rfcma_pkg::CFG_OFFSET:      cfg_q.offset      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign in_stall_o = !calib_ready;

  rfcma_calib u_calib (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (calib_ready),
    .in_data_i   (in_data_i),
    .out_valid_o (cal_valid),
    .out_ready_i (win_ready),
    .out_data_o  (cal_data)
  );

  rfcma_window #(
    .WINDOW       (WINDOW),
    .MAX_ACCEPTED (MAX_ACCEPTED),
    .OUT_CAPACITY (OUT_CAPACITY),
    .SUM_W        (SUM_W)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cal_valid),
    .in_ready_o  (win_ready),
    .in_data_i   (cal_data),
    .out_valid_o (win_valid),
    .out_ready_i (div_ready),
    .out_sum_o   (win_sum),
    .out_ctl_o   (win_ctl)
  );

  rfcma_divide #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_divide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (win_valid),
    .in_ready_o  (div_ready),
    .in_sum_i    (win_sum),
    .in_ctl_i    (win_ctl),
    .out_valid_o (out_valid_o),
    .out_ready_i (!out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for range_filter_calibrate_moving_average_unit.
// Holds a behavioral predictor of the range filter, calibration and window mean.
// Depends on rfcma_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module testbench;

  localparam int WIN_LEN     = 8;
  localparam int MAX_KEPT    = 256;
  localparam int MAX_MEANS   = 256;
  localparam int CYCLE_LIMIT = 400000;

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_we;
  logic [1:0]                  cfg_index;
  logic [rfcma_pkg::CFG_W-1:0] cfg_data;
  logic                        sample_valid;
  logic                        sample_stall;
  rfcma_pkg::in_t              sample_data;
  logic                        mean_valid;
  logic                        mean_stall = 1'b0;
  rfcma_pkg::out_t             mean_data;

  logic signed [rfcma_pkg::RAW_W-1:0] lo_lim;
  logic signed [rfcma_pkg::RAW_W-1:0] hi_lim;
  logic signed [rfcma_pkg::RAW_W-1:0] gain_q;
  logic signed [rfcma_pkg::CAL_W-1:0] offs;
  logic signed [rfcma_pkg::CAL_W-1:0] win_store [WIN_LEN];
  longint                             win_sum;
  int                                 kept_cnt;
  int                                 means_cnt;

  rfcma_pkg::out_t awaited_means [$];
  rfcma_pkg::out_t want_mean;
  int              mismatches;
  int              sender_idle_pct;
  int              receiver_stall_pct;
  int              hold_left;
  int unsigned     cycles;

  range_filter_calibrate_moving_average_unit #(
    .WINDOW      (WIN_LEN),
    .MAX_ACCEPTED(MAX_KEPT),
    .OUT_CAPACITY(MAX_MEANS)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_valid_i (sample_valid),
    .in_stall_o (sample_stall),
    .in_data_i  (sample_data),
    .out_valid_o(mean_valid),
    .out_stall_i(mean_stall),
    .out_data_o (mean_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      mean_stall <= 1'b1;
      hold_left--;
    end else begin
      mean_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("ERROR at %0t: %s, got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n && mean_valid && !mean_stall) begin
      if (awaited_means.size() == 0) begin
        report_mismatch("result transaction with none awaited", mean_data.average_count, 0);
      end else begin
        want_mean = awaited_means.pop_front();
        if (mean_data.average != want_mean.average)
          report_mismatch("average", longint'(mean_data.average),
                          longint'(want_mean.average));
        if (mean_data.has_average != want_mean.has_average)
          report_mismatch("has_average", mean_data.has_average, want_mean.has_average);
        if (mean_data.batch_done != want_mean.batch_done)
          report_mismatch("batch_done", mean_data.batch_done, want_mean.batch_done);
        if (mean_data.average_count != want_mean.average_count)
          report_mismatch("average_count", mean_data.average_count,
                          want_mean.average_count);
      end
    end
  end

  function automatic logic signed [rfcma_pkg::CAL_W-1:0] calibrate(
    input logic signed [rfcma_pkg::RAW_W-1:0] raw);
    longint scaled;
    scaled = ((longint'(raw) * longint'(gain_q)) >>> 8) + longint'(offs);
    if (scaled > longint'(rfcma_pkg::CAL_MAX)) scaled = longint'(rfcma_pkg::CAL_MAX);
    if (scaled < longint'(rfcma_pkg::CAL_MIN)) scaled = longint'(rfcma_pkg::CAL_MIN);
    return rfcma_pkg::CAL_W'(scaled);
  endfunction

  task automatic advance_window(input rfcma_pkg::in_t smp);
    rfcma_pkg::out_t                    res;
    int                                 slot;
    bit                                 made;
    logic signed [rfcma_pkg::CAL_W-1:0] cal;
    res  = '0;
    made = 1'b0;
    if (smp.raw_sample >= lo_lim && smp.raw_sample <= hi_lim && kept_cnt < MAX_KEPT) begin
      slot = kept_cnt % WIN_LEN;
      cal  = calibrate(smp.raw_sample);
      if (kept_cnt >= WIN_LEN) win_sum -= longint'(win_store[slot]);
      win_store[slot] = cal;
      win_sum += longint'(cal);
      kept_cnt++;
      if (kept_cnt >= WIN_LEN && means_cnt < MAX_MEANS) begin
        res.average     = rfcma_pkg::CAL_W'(win_sum / WIN_LEN);
        res.has_average = 1'b1;
        made            = 1'b1;
        means_cnt++;
      end
    end
    if (made || smp.end_of_batch) begin
      res.batch_done    = smp.end_of_batch;
      res.average_count = (means_cnt > 511) ? rfcma_pkg::COUNT_MAX
                                            : rfcma_pkg::COUNT_W'(means_cnt);
      awaited_means.push_back(res);
    end
    if (smp.end_of_batch) begin
      kept_cnt  = 0;
      means_cnt = 0;
      win_sum   = 0;
    end
  endtask

  task automatic send_sample(input rfcma_pkg::in_t smp);
    while ($urandom_range(99) < sender_idle_pct) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample_data  <= smp;
    do @(posedge clk); while (sample_stall);
    advance_window(smp);
    @(negedge clk);
  endtask

  task automatic wait_idle(input int extra);
    sample_valid <= 1'b0;
    @(negedge clk);
    while (awaited_means.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    @(posedge clk);
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = receiver_pct;
    @(negedge clk);
  endtask

  task automatic load_config(input logic signed [rfcma_pkg::RAW_W-1:0] lo,
                             input logic signed [rfcma_pkg::RAW_W-1:0] hi,
                             input logic signed [rfcma_pkg::RAW_W-1:0] g,
                             input logic signed [rfcma_pkg::CAL_W-1:0] o);
    cfg_we    <= 1'b1;
    cfg_index <= rfcma_pkg::CFG_LOWER_LIMIT;
    cfg_data  <= {{(rfcma_pkg::CFG_W-rfcma_pkg::RAW_W){lo[rfcma_pkg::RAW_W-1]}}, lo};
    @(negedge clk);
    cfg_index <= rfcma_pkg::CFG_UPPER_LIMIT;
    cfg_data  <= {{(rfcma_pkg::CFG_W-rfcma_pkg::RAW_W){hi[rfcma_pkg::RAW_W-1]}}, hi};
    @(negedge clk);
    cfg_index <= rfcma_pkg::CFG_GAIN;
    cfg_data  <= {{(rfcma_pkg::CFG_W-rfcma_pkg::RAW_W){g[rfcma_pkg::RAW_W-1]}}, g};
    @(negedge clk);
    cfg_index <= rfcma_pkg::CFG_OFFSET;
    cfg_data  <= o;
    @(negedge clk);
    cfg_we <= 1'b0;
    lo_lim = lo;
    hi_lim = hi;
    gain_q = g;
    offs   = o;
    @(negedge clk);
  endtask

  task automatic randomize_config();
    logic signed [rfcma_pkg::RAW_W-1:0] a, b, lo, hi, g;
    logic signed [rfcma_pkg::CAL_W-1:0] o;
    int step;
    case ($urandom_range(9))
      0: begin
        lo = 16'sh8000;
        hi = 16'sh7fff;
      end
      1: begin
        lo = rfcma_pkg::RAW_W'($urandom_range(32767, 200));
        hi = lo - rfcma_pkg::RAW_W'($urandom_range(200, 1));
      end
      2: begin
        lo   = rfcma_pkg::RAW_W'($urandom);
        step = $urandom_range(300);
        step = int'(lo) + step;
        hi   = (step > 32767) ? 16'sh7fff : rfcma_pkg::RAW_W'(step);
      end
      default: begin
        a  = rfcma_pkg::RAW_W'($urandom);
        b  = rfcma_pkg::RAW_W'($urandom);
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
      end
    endcase
    case ($urandom_range(5))
      0: g = 16'sd256;
      1: g = 16'sh7fff;
      2: g = 16'sh8000;
      3: g = rfcma_pkg::RAW_W'($urandom_range(1023)) - 16'sd512;
      default: g = rfcma_pkg::RAW_W'($urandom);
    endcase
    case ($urandom_range(5))
      0: o = '0;
      1: o = 24'sh7fffff;
      2: o = 24'sh800000;
      3: o = rfcma_pkg::CAL_W'($urandom_range(2047)) - 24'sd1024;
      default: o = rfcma_pkg::CAL_W'($urandom);
    endcase
    load_config(lo, hi, g, o);
  endtask

  function automatic rfcma_pkg::in_t make_sample(input bit last);
    rfcma_pkg::in_t smp;
    int             span;
    span = int'(hi_lim) - int'(lo_lim);
    if (span >= 0 && $urandom_range(99) >= 12)
      smp.raw_sample = rfcma_pkg::RAW_W'(int'(lo_lim) + int'($urandom_range(span)));
    else
      smp.raw_sample = rfcma_pkg::RAW_W'($urandom);
    smp.end_of_batch = last;
    return smp;
  endfunction

  task automatic test_default_path();
    logic signed [rfcma_pkg::RAW_W-1:0] raws [9] = '{16'sh8000, 16'sh7fff, 16'sd0, -16'sd1,
                                                     16'sd1, 16'sh7fff, 16'sh8000, 16'sd100,
                                                     -16'sd200};
    load_config(16'sh8000, 16'sh7fff, 16'sd256, 24'sd0);
    for (int k = 0; k < 9; k++)
      send_sample(rfcma_pkg::in_t'{raw_sample: raws[k], end_of_batch: (k == 8)});
    wait_idle(8);
  endtask

  task automatic test_calibration_limits();
    logic signed [rfcma_pkg::RAW_W-1:0] raws [8] = '{16'sh7fff, 16'sh8000, 16'sh7fff, -16'sd1,
                                                     16'sh7fff, 16'sh8000, 16'sd1, 16'sh7fff};
    load_config(16'sh8000, 16'sh7fff, 16'sh7fff, 24'sh7fffff);
    for (int k = 0; k < 8; k++)
      send_sample(rfcma_pkg::in_t'{raw_sample: raws[k], end_of_batch: (k == 7)});
    wait_idle(8);
    load_config(16'sh8000, 16'sh7fff, 16'sh8000, 24'sh800000);
    for (int k = 0; k < 8; k++)
      send_sample(rfcma_pkg::in_t'{raw_sample: raws[k], end_of_batch: (k == 7)});
    wait_idle(8);
  endtask

  task automatic test_empty_range();
    load_config(16'sd10, -16'sd10, 16'sd256, 24'sd0);
    send_sample(rfcma_pkg::in_t'{raw_sample: 16'sd0, end_of_batch: 1'b0});
    send_sample(rfcma_pkg::in_t'{raw_sample: 16'sd10, end_of_batch: 1'b0});
    send_sample(rfcma_pkg::in_t'{raw_sample: -16'sd10, end_of_batch: 1'b1});
    wait_idle(8);
  endtask

  task automatic test_drained_sender();
    set_idling(0, 30);
    randomize_config();
    for (int k = 0; k < 20; k++) begin
      send_sample(make_sample(k % 10 == 9));
      wait_idle(0);
    end
    wait_idle(8);
  endtask

  task automatic test_receiver_holdoff();
    set_idling(0, 0);
    load_config(16'sh8000, 16'sh7fff, rfcma_pkg::RAW_W'($urandom),
                rfcma_pkg::CAL_W'($urandom));
    @(posedge clk);
    hold_left = 200;
    @(negedge clk);
    for (int k = 0; k < 60; k++) send_sample(make_sample(k == 59));
    wait_idle(8);
  endtask

  task automatic test_accept_limit();
    set_idling(25, 25);
    load_config(16'sh8000, 16'sh7fff, rfcma_pkg::RAW_W'($urandom_range(1023)) - 16'sd512,
                rfcma_pkg::CAL_W'($urandom));
    for (int k = 0; k < 301; k++) send_sample(make_sample(k == 300));
    wait_idle(8);
  endtask

  task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                     input int n_items);
    int             sent;
    int             len;
    rfcma_pkg::in_t smp;
    set_idling(sender_pct, receiver_pct);
    wait_idle(8);
    randomize_config();
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(3) == 0) begin
        wait_idle(8);
        randomize_config();
      end
      case ($urandom_range(9))
        0: len = $urandom_range(6, 1);
        1: len = $urandom_range(120, 40);
        default: len = $urandom_range(30, 8);
      endcase
      for (int k = 0; k < len; k++) begin
        smp = make_sample(k == len - 1 || $urandom_range(59) == 0);
        send_sample(smp);
        sent++;
      end
    end
    wait_idle(8);
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = rfcma_pkg::CFG_LOWER_LIMIT;
    cfg_data           = '0;
    sample_valid       = 1'b0;
    sample_data        = '0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_left          = 0;
    mismatches         = 0;
    cycles             = 0;
    lo_lim             = 16'sh8000;
    hi_lim             = 16'sh7fff;
    gain_q             = 16'sd256;
    offs               = '0;
    win_sum            = 0;
    kept_cnt           = 0;
    means_cnt          = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_default_path();
    test_calibration_limits();
    test_empty_range();
    test_drained_sender();
    test_receiver_holdoff();
    test_accept_limit();
    test_random_traffic(0, 0, 250);
    test_random_traffic(84, 0, 250);
    test_random_traffic(0, 84, 250);
    test_random_traffic(25, 25, 250);

    wait_idle(12);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/rfcma_pkg.sv
sv/rfcma_ram.sv
sv/rfcma_calib.sv
sv/rfcma_window.sv
sv/rfcma_divide.sv
sv/range_filter_calibrate_moving_average_unit.sv
sim/testbench.sv
